// File: src/assert_macros.svh
// shared assertion macros, clocked on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RISCX_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define RISCX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/riscx_pkg.sv
`default_nettype none

package riscx_pkg;

  localparam int REG_COUNT = 32;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int XLEN      = 32;
  localparam int FUNC_W    = 4;
  localparam int SHAMT_W   = 5;
  localparam int IMM_W     = 16;
  localparam int TGT_W     = 26;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  localparam logic [REG_IDX_W-1:0] LINK_REG = REG_IDX_W'(31);
  localparam logic [REG_IDX_W-1:0] ZERO_REG = '0;
  localparam logic [XLEN-1:0]      PC_STEP  = XLEN'(4);

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD  = 4'd0,
    FN_SUB  = 4'd1,
    FN_AND  = 4'd2,
    FN_OR   = 4'd3,
    FN_NOR  = 4'd4,
    FN_SLL  = 4'd5,
    FN_SRL  = 4'd6,
    FN_ADDI = 4'd7,
    FN_ANDI = 4'd8,
    FN_ORI  = 4'd9,
    FN_BEQ  = 4'd10,
    FN_BNE  = 4'd11,
    FN_JAL  = 4'd12,
    FN_JR   = 4'd13
  } func_e;

  typedef struct packed {
    func_e                func;
    logic [REG_IDX_W-1:0] rs;
    logic [REG_IDX_W-1:0] rt;
    logic [REG_IDX_W-1:0] rd;
    logic [SHAMT_W-1:0]   sa;
    logic [IMM_W-1:0]     imm;
    logic [TGT_W-1:0]     tgt;
  } instr_t;

  typedef struct packed {
    logic [XLEN-1:0]      next_address;
    logic                 wen;
    logic [REG_IDX_W-1:0] widx;
    logic [XLEN-1:0]      wval;
    logic                 taken;
  } result_t;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [XLEN-1:0]      data;
  } rf_wr_t;

endpackage

`default_nettype wire

// File: src/riscx_regfile.sv
`default_nettype none

module riscx_regfile
  import riscx_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 rd_en_i,
  input  wire logic [REG_IDX_W-1:0] rd_a_idx_i,
  input  wire logic [REG_IDX_W-1:0] rd_b_idx_i,
  output logic      [XLEN-1:0]      rd_a_data_o,
  output logic      [XLEN-1:0]      rd_b_data_o,
  input  wire rf_wr_t               wr_i
);

  logic [XLEN-1:0]      mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [XLEN-1:0]      rdata_a_q, rdata_b_q;
  logic                 rvld_a_q, rvld_b_q;
  logic [REG_IDX_W-1:0] ridx_a_q, ridx_b_q;
  logic                 fwd_vld_q;
  logic [REG_IDX_W-1:0] fwd_idx_q;
  logic [XLEN-1:0]      fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_a_q <= mem_q[rd_a_idx_i];
      rdata_b_q <= mem_q[rd_b_idx_i];
      ridx_a_q  <= rd_a_idx_i;
      ridx_b_q  <= rd_b_idx_i;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rvld_a_q <= 1'b0;
      rvld_b_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rvld_a_q <= vld_q[rd_a_idx_i];
        rvld_b_q <= vld_q[rd_b_idx_i];
      end
      if (wr_i.en) begin
        vld_q[wr_i.idx] <= 1'b1;
      end
    end
  end

  // last write, covers a read issued on the same edge as the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (wr_i.en) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      fwd_idx_q  <= wr_i.idx;
      fwd_data_q <= wr_i.data;
    end
  end

  always_comb begin
    if (fwd_vld_q && (fwd_idx_q == ridx_a_q)) begin
      rd_a_data_o = fwd_data_q;
    end else begin
      rd_a_data_o = rvld_a_q ? rdata_a_q : '0;
    end
    if (fwd_vld_q && (fwd_idx_q == ridx_b_q)) begin
      rd_b_data_o = fwd_data_q;
    end else begin
      rd_b_data_o = rvld_b_q ? rdata_b_q : '0;
    end
  end

endmodule

`default_nettype wire

// File: src/riscx_alu.sv
`default_nettype none

module riscx_alu
  import riscx_pkg::*;
(
  input  wire instr_t          instr_i,
  input  wire logic [XLEN-1:0] a_i,
  input  wire logic [XLEN-1:0] b_i,
  input  wire logic [XLEN-1:0] pc_i,
  output result_t              res_o
);

  logic [XLEN-1:0] imm_zx;
  logic [XLEN-1:0] br_target;
  logic [XLEN-1:0] pc_inc;
  result_t         r;

  always_comb begin
    imm_zx    = XLEN'(instr_i.imm);
    br_target = pc_i + {{(XLEN-IMM_W-2){instr_i.imm[IMM_W-1]}}, instr_i.imm, 2'b00};
    pc_inc    = pc_i + PC_STEP;

    r.next_address = pc_inc;
    r.wen          = 1'b0;
    r.widx         = ZERO_REG;
    r.wval         = '0;
    r.taken        = 1'b0;

    case (instr_i.func)
      FN_ADD: begin
        r.wen = 1'b1; r.widx = instr_i.rd; r.wval = a_i + b_i;
      end
      FN_SUB: begin
        r.wen = 1'b1; r.widx = instr_i.rd; r.wval = a_i - b_i;
      end
      FN_AND: begin
        r.wen = 1'b1; r.widx = instr_i.rd; r.wval = a_i & b_i;
      end
      FN_OR: begin
        r.wen = 1'b1; r.widx = instr_i.rd; r.wval = a_i | b_i;
      end
      FN_NOR: begin
        r.wen = 1'b1; r.widx = instr_i.rd; r.wval = ~(a_i | b_i);
      end
      FN_SLL: begin
        r.wen = 1'b1; r.widx = instr_i.rd; r.wval = b_i << instr_i.sa;
      end
      FN_SRL: begin
        r.wen = 1'b1; r.widx = instr_i.rd; r.wval = b_i >> instr_i.sa;
      end
      FN_ADDI: begin
        r.wen = 1'b1; r.widx = instr_i.rt; r.wval = a_i + imm_zx;
      end
      FN_ANDI: begin
        r.wen = 1'b1; r.widx = instr_i.rt; r.wval = a_i & imm_zx;
      end
      FN_ORI: begin
        r.wen = 1'b1; r.widx = instr_i.rt; r.wval = a_i | imm_zx;
      end
      FN_BEQ: begin
        if (a_i == b_i) begin
          r.taken = 1'b1; r.next_address = br_target;
        end
      end
      FN_BNE: begin
        if (a_i != b_i) begin
          r.taken = 1'b1; r.next_address = br_target;
        end
      end
      FN_JAL: begin
        r.wen          = 1'b1;
        r.widx         = LINK_REG;
        r.wval         = pc_inc;
        r.taken        = 1'b1;
        r.next_address = {{(XLEN-TGT_W-2){1'b0}}, instr_i.tgt, 2'b00};
      end
      FN_JR: begin
        r.taken = 1'b1; r.next_address = a_i;
      end
      default: begin
        r.wen = 1'b0;
      end
    endcase

    // writes to register zero are dropped and reported as no write
    if (!r.wen || (r.widx == ZERO_REG)) begin
      r.wen  = 1'b0;
      r.widx = ZERO_REG;
      r.wval = '0;
    end
    res_o = r;
  end

endmodule

`default_nettype wire

// File: src/risc_integer_execute_unit_core.sv
// channel  dir  tdata fields (low bit up)
// s_axis   in   func[3:0] src_a_index[8:4] src_b_index[13:9] dest_index[18:14]
//               shift_amount[23:19] immediate[39:24] jump_target[65:40]
// m_axis   out  next_address[31:0] write_enable[32] write_index[37:33]
//               write_value[69:38] branch_taken[70]
// cfg      in   start_address, written when cfg_wen_i is high
//
// one item per cycle while the output is not stalled; an item passes the execute
// register, then the output register. the accepting edge reads rs and rt from the
// register file ram; the execute stage then runs, and the edge on which it advances
// writes back and loads the output register (back-to-back hazards bypassed)
// after reset all registers read zero and the pc is zero; a config write
// reloads the pc
// a stalled output holds the execute stage, which then stops taking items
`default_nettype none

module risc_integer_execute_unit_core
  import riscx_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // func, src_a_index, src_b_index, dest_index, shift_amount, immediate,
  // jump_target, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // next_address, write_enable, write_index, write_value, branch_taken, zero pad
  output logic      [OUT_DATA_W-1:0] m_axis_tdata_o,
  input  wire logic                  cfg_wen_i,
  input  wire logic [XLEN-1:0]       cfg_wdata_i
);

  instr_t          in_instr;
  instr_t          ex_instr_q;
  logic            ex_valid_q, ex_valid_d;
  logic            m_valid_q, m_valid_d;
  result_t         m_res_q;
  logic [XLEN-1:0] pc_q, pc_d;
  logic            s_fire;
  logic            ex_adv;
  logic [XLEN-1:0] op_a, op_b;
  result_t         ex_res;
  rf_wr_t          rf_wr;

  assign in_instr.func = func_e'(s_axis_tdata_i[3:0]);
  assign in_instr.rs   = s_axis_tdata_i[8:4];
  assign in_instr.rt   = s_axis_tdata_i[13:9];
  assign in_instr.rd   = s_axis_tdata_i[18:14];
  assign in_instr.sa   = s_axis_tdata_i[23:19];
  assign in_instr.imm  = s_axis_tdata_i[39:24];
  assign in_instr.tgt  = s_axis_tdata_i[65:40];

  assign ex_adv          = ex_valid_q && (!m_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !ex_valid_q || ex_adv;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  riscx_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (s_fire),
    .rd_a_idx_i (in_instr.rs),
    .rd_b_idx_i (in_instr.rt),
    .rd_a_data_o(op_a),
    .rd_b_data_o(op_b),
    .wr_i       (rf_wr)
  );

  riscx_alu u_alu (
    .instr_i(ex_instr_q),
    .a_i    (op_a),
    .b_i    (op_b),
    .pc_i   (pc_q),
    .res_o  (ex_res)
  );

  always_comb begin
    rf_wr.en   = ex_adv && ex_res.wen;
    rf_wr.idx  = ex_res.widx;
    rf_wr.data = ex_res.wval;
  end

  always_comb begin
    ex_valid_d = ex_valid_q;
    if (s_fire) begin
      ex_valid_d = 1'b1;
    end else if (ex_adv) begin
      ex_valid_d = 1'b0;
    end

    m_valid_d = m_valid_q;
    if (ex_adv) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    pc_d = pc_q;
    if (cfg_wen_i) begin
      pc_d = cfg_wdata_i;
    end else if (ex_adv) begin
      pc_d = ex_res.next_address;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      pc_q       <= '0;
    end else begin
      ex_valid_q <= ex_valid_d;
      m_valid_q  <= m_valid_d;
      pc_q       <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      ex_instr_q <= in_instr;
    end
    if (ex_adv) begin
      m_res_q <= ex_res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_res_q.taken, m_res_q.wval, m_res_q.widx,
                            m_res_q.wen, m_res_q.next_address};

endmodule

`default_nettype wire

// File: src/riscx_checker.sv
`default_nettype none

`include "assert_macros.svh"

module riscx_checker
  import riscx_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire logic                  cfg_wen_i,
  input wire logic [XLEN-1:0]       cfg_wdata_i
);

  logic s_fire;
  logic out_stall;
  logic in_seen;

  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_seen   = (^s_axis_tdata_i) || !(^s_axis_tdata_i) || cfg_wen_i || (|cfg_wdata_i);

  `RISCX_ASSERT_NEXT(a_out_valid_holds, out_stall, m_axis_tvalid_o)
  `RISCX_ASSERT_NEXT(a_out_data_holds, out_stall, $stable(m_axis_tdata_o))
  `RISCX_ASSERT(a_stall_only_on_full, in_seen && !s_axis_tready_o, out_stall)
  `RISCX_ASSERT_NEXT(a_item_reaches_out, s_fire ##1 (!m_axis_tvalid_o || m_axis_tready_i), m_axis_tvalid_o)

endmodule

bind risc_integer_execute_unit_core riscx_checker u_checker (.*);

`default_nettype wire

// File: sim/risc_integer_execute_unit_core_test.sv
`timescale 1ns / 1ps

module risc_integer_execute_unit_core_test;
  import riscx_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 40;
  localparam logic [FUNC_W-1:0] FN_UNUSED_E = 4'd14;
  localparam logic [FUNC_W-1:0] FN_UNUSED_F = 4'd15;
  localparam int RX_OPEN   = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_PULSED = 2;

  typedef struct {
    logic [FUNC_W-1:0]    func;
    logic [REG_IDX_W-1:0] rs;
    logic [REG_IDX_W-1:0] rt;
    logic [REG_IDX_W-1:0] rd;
    logic [SHAMT_W-1:0]   sa;
    logic [IMM_W-1:0]     imm;
    logic [TGT_W-1:0]     tgt;
  } insn_t;

  typedef struct {
    logic [XLEN-1:0]      next_address;
    logic                 wen;
    logic [REG_IDX_W-1:0] widx;
    logic [XLEN-1:0]      wval;
    logic                 taken;
  } retire_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  // func, src_a_index, src_b_index, dest_index, shift_amount, immediate,
  // jump_target, zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  // next_address, write_enable, write_index, write_value, branch_taken, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_wen_i;
  logic [XLEN-1:0]       cfg_wdata_i;

  logic [XLEN-1:0] gpr [REG_COUNT];
  logic [XLEN-1:0] pc_model;
  retire_t         retire_q[$];
  retire_t         got_retire;
  retire_t         want_retire;
  int unsigned     mismatches = 0;
  int unsigned     cycle_count = 0;
  int unsigned     rx_tick = 0;
  int              rx_mode = RX_OPEN;

  risc_integer_execute_unit_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_wen_i       (cfg_wen_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic retire_t execute_insn(insn_t op);
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] pc_now;
    logic [XLEN-1:0] offset;
    retire_t r;
    a = (op.rs == ZERO_REG) ? '0 : gpr[op.rs];
    b = (op.rt == ZERO_REG) ? '0 : gpr[op.rt];
    pc_now = pc_model;
    offset = {{(XLEN-IMM_W){op.imm[IMM_W-1]}}, op.imm};
    r.next_address = pc_now + PC_STEP;
    r.wen = 1'b0;
    r.widx = '0;
    r.wval = '0;
    r.taken = 1'b0;
    case (op.func)
      FN_ADD: begin
        r.wen = 1'b1; r.widx = op.rd; r.wval = a + b;
      end
      FN_SUB: begin
        r.wen = 1'b1; r.widx = op.rd; r.wval = a - b;
      end
      FN_AND: begin
        r.wen = 1'b1; r.widx = op.rd; r.wval = a & b;
      end
      FN_OR: begin
        r.wen = 1'b1; r.widx = op.rd; r.wval = a | b;
      end
      FN_NOR: begin
        r.wen = 1'b1; r.widx = op.rd; r.wval = ~(a | b);
      end
      FN_SLL: begin
        r.wen = 1'b1; r.widx = op.rd; r.wval = b << op.sa;
      end
      FN_SRL: begin
        r.wen = 1'b1; r.widx = op.rd; r.wval = b >> op.sa;
      end
      FN_ADDI: begin
        r.wen = 1'b1; r.widx = op.rt; r.wval = a + {{(XLEN-IMM_W){1'b0}}, op.imm};
      end
      FN_ANDI: begin
        r.wen = 1'b1; r.widx = op.rt; r.wval = a & {{(XLEN-IMM_W){1'b0}}, op.imm};
      end
      FN_ORI: begin
        r.wen = 1'b1; r.widx = op.rt; r.wval = a | {{(XLEN-IMM_W){1'b0}}, op.imm};
      end
      FN_BEQ: begin
        if (a == b) begin
          r.taken = 1'b1; r.next_address = pc_now + (offset << 2);
        end
      end
      FN_BNE: begin
        if (a != b) begin
          r.taken = 1'b1; r.next_address = pc_now + (offset << 2);
        end
      end
      FN_JAL: begin
        r.wen = 1'b1; r.widx = LINK_REG; r.wval = pc_now + PC_STEP;
        r.taken = 1'b1; r.next_address = {{(XLEN-TGT_W-2){1'b0}}, op.tgt, 2'b00};
      end
      FN_JR: begin
        r.taken = 1'b1; r.next_address = a;
      end
      default: begin
      end
    endcase
    if (r.wen && r.widx == ZERO_REG) r.wen = 1'b0;
    if (r.wen) begin
      gpr[r.widx] = r.wval;
    end else begin
      r.widx = '0;
      r.wval = '0;
    end
    pc_model = r.next_address;
    return r;
  endfunction

  function automatic insn_t mk(logic [FUNC_W-1:0] func, logic [REG_IDX_W-1:0] rs,
                               logic [REG_IDX_W-1:0] rt, logic [REG_IDX_W-1:0] rd,
                               logic [SHAMT_W-1:0] sa, logic [IMM_W-1:0] imm,
                               logic [TGT_W-1:0] tgt);
    insn_t op;
    op.func = func; op.rs = rs; op.rt = rt; op.rd = rd;
    op.sa = sa; op.imm = imm; op.tgt = tgt;
    return op;
  endfunction

  // half the picks come from a few registers so results feed each other
  function automatic logic [REG_IDX_W-1:0] pick_reg();
    if ($urandom_range(0, 1) == 0) return REG_IDX_W'($urandom_range(0, 31));
    return REG_IDX_W'($urandom_range(1, 4));
  endfunction

  function automatic insn_t random_insn();
    insn_t op;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) op.func = FUNC_W'($urandom_range(14, 15));
    else if (pick < 16) op.func = FN_ORI;
    else if (pick < 28) op.func = FN_ADDI;
    else op.func = FUNC_W'($urandom_range(0, 13));
    op.rs = pick_reg();
    op.rt = pick_reg();
    op.rd = pick_reg();
    op.sa = SHAMT_W'($urandom);
    op.imm = IMM_W'($urandom);
    op.tgt = TGT_W'($urandom);
    if ((op.func == FN_BEQ || op.func == FN_BNE) && $urandom_range(0, 4) < 2)
      op.rt = op.rs;
    return op;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_insn(insn_t op);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {{(IN_DATA_W-66){1'b0}}, op.tgt, op.imm, op.sa, op.rd, op.rt,
                       op.rs, op.func};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    retire_q.push_back(execute_insn(op));
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int unsigned cycles);
    if (cycles > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (retire_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_start_address(logic [XLEN-1:0] addr);
    cfg_wen_i <= 1'b1;
    cfg_wdata_i <= addr;
    pc_model = addr;
    @(negedge clk_i);
    cfg_wen_i <= 1'b0;
  endtask

  task automatic test_directed_ops();
    insn_t prog[$];
    write_start_address('0);
    prog.push_back(mk(FN_ORI, 0, 1, 0, 0, 16'hFFFF, 0));
    prog.push_back(mk(FN_SLL, 0, 1, 2, 16, 0, 0));
    prog.push_back(mk(FN_OR, 2, 1, 3, 0, 0, 0));
    prog.push_back(mk(FN_ADD, 3, 3, 4, 0, 0, 0));
    prog.push_back(mk(FN_SUB, 0, 3, 5, 0, 0, 0));
    prog.push_back(mk(FN_AND, 2, 3, 6, 0, 0, 0));
    prog.push_back(mk(FN_NOR, 0, 0, 7, 0, 0, 0));
    prog.push_back(mk(FN_SRL, 0, 3, 8, 31, 0, 0));
    prog.push_back(mk(FN_SLL, 0, 3, 9, 0, 0, 0));
    prog.push_back(mk(FN_ADDI, 3, 10, 0, 0, 16'hFFFF, 0));
    prog.push_back(mk(FN_ANDI, 3, 11, 0, 0, 16'h8000, 0));
    // writes to register zero are dropped
    prog.push_back(mk(FN_ADD, 3, 3, 0, 0, 0, 0));
    prog.push_back(mk(FN_ORI, 3, 0, 0, 0, 16'h1234, 0));
    // branch backward past address zero
    prog.push_back(mk(FN_BEQ, 3, 3, 0, 0, 16'h8000, 0));
    prog.push_back(mk(FN_BEQ, 1, 2, 0, 0, 16'h0004, 0));
    prog.push_back(mk(FN_BNE, 1, 2, 0, 0, 16'h7FFF, 0));
    prog.push_back(mk(FN_BNE, 0, 0, 0, 0, 16'hFFFF, 0));
    prog.push_back(mk(FN_JAL, 0, 0, 0, 0, 0, 26'h3FF_FFFF));
    prog.push_back(mk(FN_JR, 31, 0, 0, 0, 0, 0));
    prog.push_back(mk(FN_JAL, 0, 0, 0, 0, 0, 0));
    prog.push_back(mk(FN_JR, 3, 0, 0, 0, 0, 0));
    prog.push_back(mk(FN_ADD, 31, 31, 31, 31, 16'hFFFF, 26'h3FF_FFFF));
    prog.push_back(mk(FN_UNUSED_E, 31, 31, 31, 31, 16'hFFFF, 26'h3FF_FFFF));
    prog.push_back(mk(FN_UNUSED_F, 31, 31, 31, 31, 16'hFFFF, 26'h3FF_FFFF));
    prog.push_back(mk(FN_JR, 0, 0, 0, 0, 0, 0));
    foreach (prog[i]) send_insn(prog[i]);
  endtask

  task automatic test_start_address();
    logic [XLEN-1:0] addrs[$];
    addrs = '{32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000, $urandom};
    foreach (addrs[i]) begin
      wait_drained();
      write_start_address(addrs[i]);
      repeat (6) send_insn(random_insn());
    end
  endtask

  task automatic test_random_stream(int unsigned total);
    int unsigned left;
    int unsigned burst;
    bit mid_drained;
    logic [XLEN-1:0] addrs[$];
    addrs = '{$urandom, 32'h0000_0000, 32'hFFFF_FFFF, $urandom & 32'hFFFF_FFFC};
    foreach (addrs[p]) begin
      wait_drained();
      write_start_address(addrs[p]);
      left = total / addrs.size();
      mid_drained = 1'b0;
      while (left > 0) begin
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        while (burst > 0 && left > 0) begin
          send_insn(random_insn());
          burst--;
          left--;
        end
        if ($urandom_range(0, 7) == 0) idle_sender($urandom_range(8, 20));
        else idle_sender($urandom_range(0, 4));
        // let the pipe run empty once, midway through the second phase
        if (p == 1 && !mid_drained && left <= total / addrs.size() / 2) begin
          wait_drained();
          mid_drained = 1'b1;
        end
      end
    end
  endtask

  always @(negedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 96 == 0) rx_mode <= $urandom_range(RX_OPEN, RX_PULSED);
    case (rx_mode)
      RX_OPEN:   m_axis_tready_i <= 1'b1;
      RX_RANDOM: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      default:   m_axis_tready_i <= ((rx_tick % 8) < 3);
    endcase
  end

  task automatic report_field(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
    if (want !== got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t %s mismatch expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_retire.next_address = m_axis_tdata_o[31:0];
      got_retire.wen          = m_axis_tdata_o[32];
      got_retire.widx         = m_axis_tdata_o[37:33];
      got_retire.wval         = m_axis_tdata_o[69:38];
      got_retire.taken        = m_axis_tdata_o[70];
      if (retire_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t unexpected item expected none actual %h", $time, m_axis_tdata_o);
        mismatches++;
      end else begin
        want_retire = retire_q.pop_front();
        report_field("next_address", want_retire.next_address, got_retire.next_address);
        report_field("write_enable", XLEN'(want_retire.wen), XLEN'(got_retire.wen));
        report_field("write_index", XLEN'(want_retire.widx), XLEN'(got_retire.widx));
        report_field("write_value", want_retire.wval, got_retire.wval);
        report_field("branch_taken", XLEN'(want_retire.taken), XLEN'(got_retire.taken));
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    cfg_wen_i = 1'b0;
    cfg_wdata_i = '0;
    foreach (gpr[i]) gpr[i] = '0;
    pc_model = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_ops();
    test_start_address();
    test_random_stream(1800);
    wait_drained();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
